@@ hw/rtl/prime_implicant_finder_core_macros.svh @@
// assertion macros used by the prime implicant finder checker
`ifndef PRIME_IMPLICANT_FINDER_CORE_MACROS_SVH
`define PRIME_IMPLICANT_FINDER_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PIF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PIF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// expression must never be true
`define PIF_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

@@ hw/rtl/pif_pkg.sv @@
// shared types, constants and helper functions of the prime implicant finder
package pif_pkg;

  localparam int NUM_VARS    = 4;
  localparam int TERM_SPACE  = 1 << NUM_VARS;
  localparam int VC_W        = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int SEQ_W       = VC_W + 2 * NUM_VARS;

  typedef logic [NUM_VARS-1:0]   cube_bits_t;
  typedef logic [TERM_SPACE-1:0] term_set_t;
  typedef logic [VC_W-1:0]       var_count_t;

  // one stored prime
  typedef struct packed {
    logic       essential;
    cube_bits_t care_mask;
    cube_bits_t value_bits;
  } prime_entry_t;

  // what the cube evaluator reports for one candidate
  typedef struct packed {
    logic      prime;
    term_set_t covered;
  } cube_eval_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_COUNT,
    ST_MARK,
    ST_READ,
    ST_WAIT,
    ST_SEND
  } state_t;

  // clamp the raw register to 1..NUM_VARS
  function automatic var_count_t active_vars(input var_count_t raw);
    var_count_t n;
    n = raw;
    if (n == '0) n = var_count_t'(1);
    if (n > var_count_t'(NUM_VARS)) n = var_count_t'(NUM_VARS);
    return n;
  endfunction

  // mask of the low n variable bits
  function automatic cube_bits_t var_mask(input var_count_t n);
    cube_bits_t m;
    for (int b = 0; b < NUM_VARS; b++) begin
      m[b] = (var_count_t'(b) < n);
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/pif_ram.sv @@
// generic single-write, single-read ram with registered read data
module pif_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/pif_cube_eval.sv @@
// cube evaluator: tests one candidate cube for primality and on-set coverage
module pif_cube_eval (
  input  pif_pkg::cube_bits_t value_bits,
  input  pif_pkg::cube_bits_t care_mask,
  input  pif_pkg::var_count_t n_vars,
  input  pif_pkg::term_set_t  on_set,
  input  pif_pkg::term_set_t  dc_set,
  output pif_pkg::cube_eval_t result
);

  import pif_pkg::*;

  term_set_t  lane_en;
  term_set_t  all_set;
  cube_bits_t full;
  cube_bits_t grow_ok;
  logic       in_set;

  // true when every active minterm of the cube lies in s
  function automatic logic cube_inside(input cube_bits_t v, input cube_bits_t c,
                                       input term_set_t s, input term_set_t en);
    logic ok;
    ok = 1'b1;
    for (int m = 0; m < TERM_SPACE; m++) begin
      if (en[m] && ((cube_bits_t'(m) & c) == v) && !s[m]) ok = 1'b0;
    end
    return ok;
  endfunction

  // minterms that exist for the active variable count
  always_comb begin
    full = var_mask(n_vars);
    for (int m = 0; m < TERM_SPACE; m++) begin
      lane_en[m] = ((cube_bits_t'(m) & ~full) == '0);
    end
  end

  assign all_set = on_set | dc_set;
  assign in_set  = cube_inside(value_bits, care_mask, all_set, lane_en);

  // freeing any fixed variable must leave the set for a prime
  always_comb begin
    for (int b = 0; b < NUM_VARS; b++) begin
      grow_ok[b] = care_mask[b] &&
                   cube_inside(value_bits & ~(cube_bits_t'(1) << b),
                               care_mask & ~(cube_bits_t'(1) << b),
                               all_set, lane_en);
    end
  end

  // primality and on-set minterms covered
  always_comb begin
    result.prime = in_set && (grow_ok == '0);
    for (int m = 0; m < TERM_SPACE; m++) begin
      result.covered[m] = lane_en[m] && ((cube_bits_t'(m) & care_mask) == value_bits) &&
                          on_set[m];
    end
  end

endmodule

@@ hw/rtl/prime_implicant_finder_core.sv @@
// prime implicant finder top level: term loading, cube sequencer, prime store
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+----------------------------------------
//  in_     | in  | in_tvalid/in_tready   | tdata term, tuser is_dont_care, tlast
//  out_    | out | out_tvalid/out_tready | tdata value/care/ess/ovf, tuser valid
//  cfg_    | in  | cfg_valid/cfg_ready   | cfg_data number of variables
//
//  terms load at one per cycle; the item with tlast starts the solve
//  solve: one candidate cube per cycle through the shared cube evaluator, first a coverage
//  count pass then a marking and store pass
//  results: each prime is read from the store read port through ST_READ, ST_WAIT and ST_SEND
//  synchronous active-low reset returns to loading with empty sets and four variables
//  in_tready stays low from the solve start until the final result transfer
module prime_implicant_finder_core #(
  parameter int PRIME_SLOTS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // term[3:0], zero fill
  input  logic [pif_pkg::IN_TDATA_W-1:0]   in_tdata,
  // is_dont_care
  input  logic                             in_tuser,
  input  logic                             in_tlast,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // value_bits[3:0], care_mask[7:4], essential[8], overflow[9], zero fill
  output logic [pif_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // valid_res
  output logic                             out_tuser,
  output logic                             out_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [pif_pkg::VC_W-1:0]         cfg_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready
);

  import pif_pkg::*;

  localparam int AW = (PRIME_SLOTS > 1) ? $clog2(PRIME_SLOTS) : 1;
  localparam int CW = $clog2(PRIME_SLOTS + 1);

  state_t            state_r, state_nxt;
  var_count_t        vc_r;
  var_count_t        n_vars;
  cube_bits_t        full;
  term_set_t         on_r, on_nxt;
  term_set_t         dc_r, dc_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [1:0]        cnt_r [TERM_SPACE];
  logic [1:0]        cnt_nxt [TERM_SPACE];
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              over_r, over_nxt;
  logic [OUT_TDATA_W-1:0] odata_r, odata_nxt;
  logic              olast_r, olast_nxt;
  logic              ouser_r, ouser_nxt;

  var_count_t        seq_k;
  cube_bits_t        seq_v;
  cube_bits_t        seq_c;
  var_count_t        care_pop;
  logic              cand_ok;
  logic              seq_last;
  logic              is_prime;
  logic              ess;
  logic              in_xfer;
  logic              out_xfer;
  logic              store_full;
  cube_eval_t        ev;
  prime_entry_t      wr_entry;
  prime_entry_t      rd_entry;
  logic [$bits(prime_entry_t)-1:0] rd_raw;
  logic              ram_we;
  logic              ram_re;
  cube_bits_t        term_cut;

  assign n_vars    = active_vars(vc_r);
  assign full      = var_mask(n_vars);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;
  assign cfg_ready = 1'b1;

  // candidate cube from the sequencer: free count, value, care mask
  assign seq_k = seq_r[SEQ_W-1 -: VC_W];
  assign seq_v = seq_r[2*NUM_VARS-1 -: NUM_VARS];
  assign seq_c = seq_r[NUM_VARS-1:0];

  always_comb begin
    care_pop = '0;
    for (int b = 0; b < NUM_VARS; b++) begin
      care_pop = care_pop + var_count_t'(seq_c[b]);
    end
  end

  assign cand_ok = (seq_k <= n_vars) && (((seq_v | seq_c) & ~full) == '0) &&
                   ((seq_v & ~seq_c) == '0) && (care_pop == (n_vars - seq_k));
  assign seq_last = (seq_k == n_vars) && (seq_v == '1) && (seq_c == '1);

  // shared cube evaluator
  pif_cube_eval u_eval (
    .value_bits (seq_v),
    .care_mask  (seq_c),
    .n_vars     (n_vars),
    .on_set     (on_r),
    .dc_set     (dc_r),
    .result     (ev)
  );

  assign is_prime = cand_ok && ev.prime;

  // essential when some covered minterm has exactly one covering prime
  always_comb begin
    ess = 1'b0;
    for (int m = 0; m < TERM_SPACE; m++) begin
      if (ev.covered[m] && (cnt_r[m] == 2'd1)) ess = 1'b1;
    end
  end

  assign store_full = (count_r >= CW'(PRIME_SLOTS));
  assign wr_entry   = '{essential: ess, care_mask: seq_c, value_bits: seq_v};
  assign rd_entry   = prime_entry_t'(rd_raw);
  assign term_cut   = in_tdata[NUM_VARS-1:0] & full;

  // prime store
  pif_ram #(
    .WIDTH ($bits(prime_entry_t)),
    .DEPTH (PRIME_SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (rd_raw)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:  if (in_xfer && in_tlast) state_nxt = ST_COUNT;
      ST_COUNT: if (seq_last) state_nxt = ST_MARK;
      ST_MARK: begin
        if (seq_last) begin
          if ((count_r != '0) || (is_prime && !store_full)) state_nxt = ST_READ;
          else state_nxt = ST_SEND;
        end
      end
      ST_READ:  state_nxt = ST_WAIT;
      ST_WAIT:  state_nxt = ST_SEND;
      ST_SEND: begin
        if (out_xfer) state_nxt = out_tlast ? ST_LOAD : ST_READ;
      end
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    unique case (state_r)
      ST_LOAD:  in_tready = 1'b1;
      ST_COUNT: ;
      ST_MARK:  ram_we = is_prime && !store_full;
      ST_READ:  ram_re = 1'b1;
      ST_WAIT:  ;
      ST_SEND:  out_tvalid = 1'b1;
      default:  ;
    endcase
  end

  // datapath next values
  always_comb begin
    on_nxt     = on_r;
    dc_nxt     = dc_r;
    seq_nxt    = seq_r;
    count_nxt  = count_r;
    rd_idx_nxt = rd_idx_r;
    over_nxt   = over_r;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    ouser_nxt  = ouser_r;
    for (int m = 0; m < TERM_SPACE; m++) begin
      cnt_nxt[m] = cnt_r[m];
    end
    unique case (state_r)
      ST_LOAD: begin
        // add the term to its set, clear solve state on the last one
        if (in_xfer) begin
          if (in_tuser) dc_nxt[term_cut] = 1'b1;
          else on_nxt[term_cut] = 1'b1;
          if (in_tlast) begin
            seq_nxt   = '0;
            count_nxt = '0;
            over_nxt  = 1'b0;
            for (int m = 0; m < TERM_SPACE; m++) begin
              cnt_nxt[m] = 2'd0;
            end
          end
        end
      end
      ST_COUNT: begin
        // saturating coverage count per on-set minterm
        if (is_prime) begin
          for (int m = 0; m < TERM_SPACE; m++) begin
            if (ev.covered[m] && (cnt_r[m] != 2'd2)) cnt_nxt[m] = cnt_r[m] + 2'd1;
          end
        end
        seq_nxt = seq_last ? '0 : seq_r + SEQ_W'(1);
      end
      ST_MARK: begin
        // store primes in emission order, flag the ones that do not fit
        if (is_prime) begin
          if (!store_full) count_nxt = count_r + CW'(1);
          else over_nxt = 1'b1;
        end
        seq_nxt = seq_r + SEQ_W'(1);
        if (seq_last) begin
          on_nxt     = '0;
          dc_nxt     = '0;
          rd_idx_nxt = '0;
          odata_nxt  = '0;
          olast_nxt  = 1'b1;
          ouser_nxt  = 1'b0;
        end
      end
      ST_READ: ;
      ST_WAIT: begin
        // registered store data into the output register
        odata_nxt = OUT_TDATA_W'({over_r, rd_entry.essential,
                                  rd_entry.care_mask, rd_entry.value_bits});
        olast_nxt = ((rd_idx_r + CW'(1)) == count_r);
        ouser_nxt = 1'b1;
      end
      ST_SEND: begin
        if (out_xfer) rd_idx_nxt = rd_idx_r + CW'(1);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      vc_r     <= var_count_t'(NUM_VARS);
      on_r     <= '0;
      dc_r     <= '0;
      seq_r    <= '0;
      count_r  <= '0;
      rd_idx_r <= '0;
      over_r   <= 1'b0;
      for (int m = 0; m < TERM_SPACE; m++) begin
        cnt_r[m] <= 2'd0;
      end
    end else begin
      state_r  <= state_nxt;
      on_r     <= on_nxt;
      dc_r     <= dc_nxt;
      seq_r    <= seq_nxt;
      count_r  <= count_nxt;
      rd_idx_r <= rd_idx_nxt;
      over_r   <= over_nxt;
      for (int m = 0; m < TERM_SPACE; m++) begin
        cnt_r[m] <= cnt_nxt[m];
      end
      if (cfg_valid && cfg_ready) begin
        vc_r <= cfg_data;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
    ouser_r <= ouser_nxt;
  end

  assign out_tdata = odata_r;
  assign out_tlast = olast_r;
  assign out_tuser = ouser_r;

endmodule

@@ hw/rtl/pif_checker.sv @@
// port-level checker for the prime implicant finder, bound to the top level
`include "prime_implicant_finder_core_macros.svh"

module pif_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pif_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            out_tuser
);

  // loading and result delivery never overlap
  `PIF_ASSERT_NEVER(a_no_overlap, in_tready && out_tvalid, "load while results pending")

  // a term without tlast keeps the block loading
  `PIF_ASSERT_NEXT(a_keep_loading, in_tvalid && in_tready && !in_tlast, in_tready, "load stopped early")

  // the last term starts the solve
  `PIF_ASSERT_NEXT(a_solve_start, in_tvalid && in_tready && in_tlast, !in_tready && !out_tvalid, "solve did not start")

  // final result closes the run
  `PIF_ASSERT_NEXT(a_run_end, out_tvalid && out_tready && out_tlast, !out_tvalid && in_tready, "run did not end")

  // stalled result holds
  `PIF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled result changed")

endmodule

bind prime_implicant_finder_core pif_checker u_pif_checker (.*);
